[design/trr_pkg.sv]
// Shared types, codes and helpers for the textured triangle rasterizer.
// No dependencies; used by trr_div and textured_triangle_rasterizer.
package trr_pkg;

  localparam int CW  = 13;  // internal coordinate width, signed
  localparam int DNW = 12;  // divider operand width
  localparam int QW  = 17;  // 1.16 weight, 0..65536
  localparam int PW  = CW + QW + 1;

  typedef logic signed [CW-1:0] crd_t;

  typedef struct packed {
    crd_t x;
    crd_t y;
    crd_t u;
    crd_t v;
  } vtx_t;

  localparam logic [1:0] KIND_TEXEL  = 2'd0;
  localparam logic [1:0] KIND_VERTEX = 2'd1;
  localparam logic [1:0] KIND_START  = 2'd2;
  localparam logic [1:0] KIND_STEP   = 2'd3;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_UPPER = 2'd1;
  localparam logic [1:0] PH_LOWER = 2'd2;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  // (c*light + 0.5) in 16.16, low 8 bits of the integer part
  function automatic logic [7:0] lit_chan(input logic [7:0] c, input logic [16:0] light);
    logic [25:0] p;
    p = 26'(c) * 26'(light) + 26'd32768;
    return p[23:16];
  endfunction

endpackage

[design/trr_div.sv]
// Restoring divider, one quotient bit per cycle: (num << 16) / den.
// Depends on trr_pkg.
module trr_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [trr_pkg::DNW-1:0]   num_i,
  input  logic [trr_pkg::DNW-1:0]   den_i,
  output logic                      done_o,
  output logic [trr_pkg::QW-1:0]    quot_o
);
  import trr_pkg::*;

  localparam int NW  = DNW + 16;
  localparam int CNW = $clog2(NW + 1);

  logic [NW-1:0]  num_q, num_d, quo_q, quo_d;
  logic [DNW-1:0] den_q;
  logic [DNW:0]   rem_q, rem_d, trial;
  logic [CNW-1:0] cnt_q, cnt_d;
  logic           run_q, run_d, done_q, done_d;
  logic           qbit;

  always_comb begin
    trial = {rem_q[DNW-1:0], num_q[NW-1]};
    qbit  = trial >= {1'b0, den_q};
    rem_d = qbit ? trial - {1'b0, den_q} : trial;
    num_d = {num_q[NW-2:0], 1'b0};
    quo_d = {quo_q[NW-2:0], qbit};
    cnt_d = cnt_q + CNW'(1);
    run_d = run_q && (cnt_q != CNW'(NW - 1));
    done_d = run_q && (cnt_q == CNW'(NW - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      if (run_q) cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= {num_i, 16'd0};
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (run_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q[QW-1:0];

endmodule

[design/textured_triangle_rasterizer.sv]
// Scanline affine texture-mapped triangle rasterizer, texture in on-chip RAM.
// Texel, vertex and idle-step transactions leave the block idle. A step runs the
// span divider, two multiplies and a RAM read, only the RAM read on a one-pixel span;
// a step that ends a row but not the triangle then sets up the next row (two divides,
// six multiplies). Start sets up the first row unless the triangle is flat. Results
// leave with a one-cycle strobe; the receiver cannot stall.
// Async active-low reset clears control state; texture RAM is not cleared.
module textured_triangle_rasterizer #(
  parameter int TEX_WORDS = 16384
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         kind_i,
  input  logic [1:0]         vertex_slot_i,
  input  logic signed [10:0] vert_x_i,
  input  logic signed [10:0] vert_y_i,
  input  logic signed [10:0] vert_u_i,
  input  logic signed [10:0] vert_v_i,
  input  logic [16:0]        light_gain_i,
  input  logic [13:0]        texel_addr_i,
  input  logic [23:0]        texel_rgb_i,
  output logic               res_strobe_o,
  output logic               pixel_valid_o,
  output logic signed [10:0] pix_x_o,
  output logic signed [10:0] pix_y_o,
  output logic [7:0]         red_o,
  output logic [7:0]         green_o,
  output logic [7:0]         blue_o,
  output logic               done_res_o
);
  import trr_pkg::*;

  localparam int AW = $clog2(TEX_WORDS);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SETUP = 4'd1;
  localparam logic [3:0] ST_DA_GO = 4'd2;
  localparam logic [3:0] ST_DA_W  = 4'd3;
  localparam logic [3:0] ST_DB_GO = 4'd4;
  localparam logic [3:0] ST_DB_W  = 4'd5;
  localparam logic [3:0] ST_MUL   = 4'd6;
  localparam logic [3:0] ST_MLAST = 4'd7;
  localparam logic [3:0] ST_SWAP  = 4'd8;
  localparam logic [3:0] ST_PD_GO = 4'd9;
  localparam logic [3:0] ST_PD_W  = 4'd10;
  localparam logic [3:0] ST_ADDR  = 4'd11;
  localparam logic [3:0] ST_OUT   = 4'd12;

  logic [23:0] tex_mem [TEX_WORDS];
  logic [23:0] tex_rd_q;

  logic [3:0]  state_q;
  logic [1:0]  phase_q;
  logic [7:0]  tex_w_q, tex_h_q;
  logic [16:0] light_q;
  vtx_t        vtx_q [3];
  vtx_t        srt_q [3];
  vtx_t        va, vb;
  crd_t        row_q, col_q;
  crd_t        sx0_q, sx1_q, su0_q, su1_q, sv0_q, sv1_q;
  logic [QW-1:0] alpha_q, beta_q;
  crd_t        lerp_q [8];
  logic [2:0]  mcnt_q, midx_q;
  logic        mpend_q;
  logic signed [PW-1:0] prod_q;
  crd_t        mbase_q;
  logic        inb_q;

  logic        accept;
  vtx_t        t0, t1, t2, tmp;

  logic          div_start, div_done;
  logic [DNW-1:0] div_num, div_den;
  logic [QW-1:0]  div_quot;

  crd_t          m_d, m_base;
  logic [QW-1:0] m_w;
  logic signed [PW-1:0] m_prod;

  crd_t        tu, tv, col_n, row_n;
  logic        inb;
  logic [15:0] taddr;

  assign accept = start && !busy;
  assign busy   = state_q != ST_IDLE;
  assign va     = (phase_q == PH_UPPER) ? srt_q[0] : srt_q[1];
  assign vb     = (phase_q == PH_UPPER) ? srt_q[1] : srt_q[2];

  // three compare-exchange steps on y
  always_comb begin
    t0  = vtx_q[0];
    t1  = vtx_q[1];
    t2  = vtx_q[2];
    tmp = '0;
    if (t0.y > t1.y) begin tmp = t0; t0 = t1; t1 = tmp; end
    if (t0.y > t2.y) begin tmp = t0; t0 = t2; t2 = tmp; end
    if (t1.y > t2.y) begin tmp = t1; t1 = t2; t2 = tmp; end
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (state_q)
      ST_DA_GO: begin
        div_start = 1'b1;
        div_num   = DNW'(row_q - srt_q[0].y);
        div_den   = DNW'(srt_q[2].y - srt_q[0].y);
      end
      ST_DB_GO: begin
        div_start = 1'b1;
        div_num   = DNW'(row_q - va.y);
        div_den   = DNW'(vb.y - va.y + crd_t'(1));
      end
      ST_PD_GO: begin
        div_start = 1'b1;
        div_num   = DNW'(col_q - sx0_q);
        div_den   = DNW'(sx1_q - sx0_q);
      end
      default: ;
    endcase
  end

  trr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // operand select for the shared lerp multiplier
  always_comb begin
    unique case (mcnt_q)
      3'd0: begin m_d = srt_q[2].x - srt_q[0].x; m_w = alpha_q; m_base = srt_q[0].x; end
      3'd1: begin m_d = vb.x - va.x;             m_w = beta_q;  m_base = va.x; end
      3'd2: begin m_d = srt_q[2].u - srt_q[0].u; m_w = alpha_q; m_base = srt_q[0].u; end
      3'd3: begin m_d = vb.u - va.u;             m_w = beta_q;  m_base = va.u; end
      3'd4: begin m_d = srt_q[2].v - srt_q[0].v; m_w = alpha_q; m_base = srt_q[0].v; end
      3'd5: begin m_d = vb.v - va.v;             m_w = beta_q;  m_base = va.v; end
      3'd6: begin m_d = su1_q - su0_q;           m_w = alpha_q; m_base = su0_q; end
      default: begin m_d = sv1_q - sv0_q;        m_w = alpha_q; m_base = sv0_q; end
    endcase
    m_prod = PW'(m_d) * $signed({1'b0, m_w});
  end

  always_comb begin
    tu    = lerp_q[6];
    tv    = lerp_q[7];
    inb   = !tu[CW-1] && !tv[CW-1] && (tu < $signed({5'd0, tex_w_q}))
            && (tv < $signed({5'd0, tex_h_q}));
    taddr = 16'(tu[7:0]) + 16'(tv[7:0]) * 16'(tex_w_q);
    col_n = col_q + crd_t'(1);
    row_n = row_q + crd_t'(1);
  end

  // texture RAM
  always_ff @(posedge clk_i) begin
    if (accept && kind_i == KIND_TEXEL && 32'(texel_addr_i) < TEX_WORDS)
      tex_mem[AW'(texel_addr_i)] <= texel_rgb_i;
    if (state_q == ST_ADDR)
      tex_rd_q <= tex_mem[AW'(taddr)];
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (div_done) begin
      if (state_q == ST_DB_W) beta_q <= div_quot;
      else alpha_q <= div_quot;
    end
    prod_q  <= m_prod;
    mbase_q <= m_base;
    midx_q  <= mcnt_q;
    if (mpend_q) lerp_q[midx_q] <= mbase_q + prod_q[CW+15:16];
    if (state_q == ST_ADDR) inb_q <= inb;
    if (state_q == ST_IDLE && accept && kind_i == KIND_STEP && phase_q != PH_IDLE
        && sx0_q == sx1_q) begin
      lerp_q[6] <= su0_q;
      lerp_q[7] <= sv0_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      phase_q       <= PH_IDLE;
      tex_w_q       <= 8'd128;
      tex_h_q       <= 8'd128;
      light_q       <= '0;
      vtx_q         <= '{default: '0};
      srt_q         <= '{default: '0};
      row_q         <= '0;
      col_q         <= '0;
      sx0_q         <= '0;
      sx1_q         <= '0;
      su0_q         <= '0;
      su1_q         <= '0;
      sv0_q         <= '0;
      sv1_q         <= '0;
      mcnt_q        <= '0;
      mpend_q       <= 1'b0;
      res_strobe_o  <= 1'b0;
      pixel_valid_o <= 1'b0;
      pix_x_o       <= '0;
      pix_y_o       <= '0;
      red_o         <= '0;
      green_o       <= '0;
      blue_o        <= '0;
      done_res_o    <= 1'b0;
    end else begin
      res_strobe_o <= 1'b0;
      mpend_q      <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_WIDTH) tex_w_q <= cfg_data_i;
        else tex_h_q <= cfg_data_i;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            unique case (kind_i)
              KIND_TEXEL: ;
              KIND_VERTEX: begin
                if (vertex_slot_i != 2'd3)
                  vtx_q[vertex_slot_i] <= '{x: CW'(vert_x_i), y: CW'(vert_y_i),
                                            u: CW'(vert_u_i), v: CW'(vert_v_i)};
              end
              KIND_START: begin
                light_q  <= light_gain_i;
                srt_q[0] <= t0;
                srt_q[1] <= t1;
                srt_q[2] <= t2;
                state_q  <= ST_SETUP;
              end
              KIND_STEP: begin
                if (phase_q == PH_IDLE) begin
                  res_strobe_o  <= 1'b1;
                  pixel_valid_o <= 1'b0;
                  pix_x_o       <= '0;
                  pix_y_o       <= '0;
                  red_o         <= '0;
                  green_o       <= '0;
                  blue_o        <= '0;
                  done_res_o    <= 1'b1;
                end else if (sx0_q == sx1_q) begin
                  state_q <= ST_ADDR;
                end else begin
                  state_q <= ST_PD_GO;
                end
              end
            endcase
          end
        end
        ST_SETUP: begin
          if (srt_q[2].y == srt_q[0].y) begin
            phase_q <= PH_IDLE;
            state_q <= ST_IDLE;
          end else begin
            row_q   <= srt_q[0].y;
            state_q <= ST_DA_GO;
          end
        end
        ST_DA_GO: begin
          phase_q <= (row_q <= srt_q[1].y) ? PH_UPPER : PH_LOWER;
          state_q <= ST_DA_W;
        end
        ST_DA_W:  if (div_done) state_q <= ST_DB_GO;
        ST_DB_GO: state_q <= ST_DB_W;
        ST_DB_W: begin
          if (div_done) begin
            mcnt_q  <= 3'd0;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          mpend_q <= 1'b1;
          mcnt_q  <= mcnt_q + 3'd1;
          if (mcnt_q == 3'd5 || mcnt_q == 3'd7) state_q <= ST_MLAST;
        end
        ST_MLAST: state_q <= (midx_q == 3'd5) ? ST_SWAP : ST_ADDR;
        ST_SWAP: begin
          if (lerp_q[0] > lerp_q[1]) begin
            sx0_q <= lerp_q[1]; sx1_q <= lerp_q[0];
            su0_q <= lerp_q[3]; su1_q <= lerp_q[2];
            sv0_q <= lerp_q[5]; sv1_q <= lerp_q[4];
            col_q <= lerp_q[1];
          end else begin
            sx0_q <= lerp_q[0]; sx1_q <= lerp_q[1];
            su0_q <= lerp_q[2]; su1_q <= lerp_q[3];
            sv0_q <= lerp_q[4]; sv1_q <= lerp_q[5];
            col_q <= lerp_q[0];
          end
          state_q <= ST_IDLE;
        end
        ST_PD_GO: state_q <= ST_PD_W;
        ST_PD_W: begin
          if (div_done) begin
            mcnt_q  <= 3'd6;
            state_q <= ST_MUL;
          end
        end
        ST_ADDR: state_q <= ST_OUT;
        ST_OUT: begin
          res_strobe_o  <= 1'b1;
          pixel_valid_o <= inb_q;
          pix_x_o       <= inb_q ? col_q[10:0] : '0;
          pix_y_o       <= inb_q ? row_q[10:0] : '0;
          red_o         <= inb_q ? lit_chan(tex_rd_q[23:16], light_q) : '0;
          green_o       <= inb_q ? lit_chan(tex_rd_q[15:8], light_q) : '0;
          blue_o        <= inb_q ? lit_chan(tex_rd_q[7:0], light_q) : '0;
          done_res_o    <= 1'b0;
          col_q         <= col_n;
          state_q       <= ST_IDLE;
          if (col_n > sx1_q) begin
            row_q <= row_n;
            if (row_n > srt_q[2].y) begin
              phase_q    <= PH_IDLE;
              done_res_o <= 1'b1;
            end else begin
              state_q <= ST_DA_GO;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // a done result always leaves the rasterizer idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && done_res_o |-> phase_q == PH_IDLE)
    else $error("done result while still rasterizing");

  // a step transaction either answers next cycle or keeps the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && kind_i == KIND_STEP |=> busy || res_strobe_o)
    else $error("step transaction dropped");

  // a divider start is never directly followed by done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> !div_done)
    else $error("divider done right after start");

endmodule

[tb/textured_triangle_rasterizer_test.sv]
// Self-checking testbench for textured_triangle_rasterizer: random triangles, texels and steps.
// A scoreboard class predicts every pixel result; depends on trr_pkg and the DUT only.
module textured_triangle_rasterizer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import trr_pkg::*;

  localparam int TEX_WORDS = 16384;

  typedef struct {
    bit         valid;
    logic [10:0] x;
    logic [10:0] y;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    bit         done;
  } pixel_t;

  class raster_scoreboard;
    logic [23:0] texture [TEX_WORDS];
    bit          written [TEX_WORDS];
    longint vx[3], vy[3], vu[3], vv[3];
    longint sx[3], sy[3], su[3], sv[3];
    logic [16:0] light;
    logic [1:0]  phase = PH_IDLE;
    longint row, col, x0, x1, u0, u1, v0, v1;
    int     width = 128;
    int     height = 128;
    pixel_t pending[$];
    int     errors, checked, drawn;

    function longint fl16(longint a);
      return a >>> 16;
    endfunction

    function logic [7:0] shade(logic [7:0] c);
      longint q;
      q = longint'(c) * longint'(light) + 32768;
      return q[23:16];
    endfunction

    function void swap_sorted(int i, int j);
      longint t;
      t = sx[i]; sx[i] = sx[j]; sx[j] = t;
      t = sy[i]; sy[i] = sy[j]; sy[j] = t;
      t = su[i]; su[i] = su[j]; su[j] = t;
      t = sv[i]; sv[i] = sv[j]; sv[j] = t;
    endfunction

    function void setup_row();
      longint tot, alpha, seg, beta, xa, xb, ua, ub, va, vb, t;
      int a, b;
      tot = sy[2] - sy[0];
      alpha = ((row - sy[0]) * 65536) / tot;
      if (row <= sy[1]) begin
        a = 0; b = 1; phase = PH_UPPER;
      end else begin
        a = 1; b = 2; phase = PH_LOWER;
      end
      seg = sy[b] - sy[a] + 1;
      beta = ((row - sy[a]) * 65536) / seg;
      xa = sx[0] + fl16((sx[2] - sx[0]) * alpha);
      xb = sx[a] + fl16((sx[b] - sx[a]) * beta);
      ua = su[0] + fl16((su[2] - su[0]) * alpha);
      ub = su[a] + fl16((su[b] - su[a]) * beta);
      va = sv[0] + fl16((sv[2] - sv[0]) * alpha);
      vb = sv[a] + fl16((sv[b] - sv[a]) * beta);
      if (xa > xb) begin
        t = xa; xa = xb; xb = t;
        t = ua; ua = ub; ub = t;
        t = va; va = vb; vb = t;
      end
      x0 = xa; x1 = xb; u0 = ua; u1 = ub; v0 = va; v1 = vb;
      col = xa;
    endfunction

    // texture word the next step reads, -1 when it draws nothing
    function longint fetch_addr();
      longint u, v, alpha;
      if (phase == PH_IDLE) return -1;
      if (x0 == x1) begin
        u = u0; v = v0;
      end else begin
        alpha = ((col - x0) * 65536) / (x1 - x0);
        u = fl16((u1 - u0) * alpha + u0 * 65536);
        v = fl16((v1 - v0) * alpha + v0 * 65536);
      end
      if (u >= 0 && u < width && v >= 0 && v < height) return (u + v * width) % TEX_WORDS;
      return -1;
    endfunction

    function void note(logic [1:0] kind, logic [1:0] slot, logic signed [10:0] x,
                       logic signed [10:0] y, logic signed [10:0] u, logic signed [10:0] v,
                       logic [16:0] gain, logic [13:0] addr, logic [23:0] rgb);
      pixel_t p;
      longint a;
      case (kind)
        KIND_TEXEL: begin
          texture[addr] = rgb;
          written[addr] = 1;
        end
        KIND_VERTEX: begin
          if (slot < 3) begin
            vx[slot] = x; vy[slot] = y; vu[slot] = u; vv[slot] = v;
          end
        end
        KIND_START: begin
          light = gain;
          sx = vx; sy = vy; su = vu; sv = vv;
          if (sy[0] > sy[1]) swap_sorted(0, 1);
          if (sy[0] > sy[2]) swap_sorted(0, 2);
          if (sy[1] > sy[2]) swap_sorted(1, 2);
          if (sy[2] == sy[0]) begin
            phase = PH_IDLE;
          end else begin
            row = sy[0];
            setup_row();
          end
        end
        default: begin
          p = '{default: 0};
          if (phase == PH_IDLE) begin
            p.done = 1;
          end else begin
            a = fetch_addr();
            if (a >= 0) begin
              p.valid = 1;
              p.x = col[10:0];
              p.y = row[10:0];
              p.r = shade(texture[a][23:16]);
              p.g = shade(texture[a][15:8]);
              p.b = shade(texture[a][7:0]);
            end
            col++;
            if (col > x1) begin
              row++;
              if (row > sy[2]) begin
                phase = PH_IDLE;
                p.done = 1;
              end else begin
                setup_row();
              end
            end
          end
          pending.push_back(p);
        end
      endcase
    endfunction

    function void check(pixel_t got);
      pixel_t e;
      if (pending.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got.valid) drawn++;
      if (got.valid !== e.valid) begin
        $error("pixel_valid: expected %0d, got %0d", e.valid, got.valid); errors++;
      end
      if (got.x !== e.x) begin
        $error("pix_x: expected %0d, got %0d", $signed(e.x), $signed(got.x)); errors++;
      end
      if (got.y !== e.y) begin
        $error("pix_y: expected %0d, got %0d", $signed(e.y), $signed(got.y)); errors++;
      end
      if (got.r !== e.r) begin
        $error("red: expected %0d, got %0d", e.r, got.r); errors++;
      end
      if (got.g !== e.g) begin
        $error("green: expected %0d, got %0d", e.g, got.g); errors++;
      end
      if (got.b !== e.b) begin
        $error("blue: expected %0d, got %0d", e.b, got.b); errors++;
      end
      if (got.done !== e.done) begin
        $error("done_res: expected %0d, got %0d", e.done, got.done); errors++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic               cfg_idx_i = 1'b0;
  logic [7:0]         cfg_data_i = '0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         kind_i = '0;
  logic [1:0]         vertex_slot_i = '0;
  logic signed [10:0] vert_x_i = '0;
  logic signed [10:0] vert_y_i = '0;
  logic signed [10:0] vert_u_i = '0;
  logic signed [10:0] vert_v_i = '0;
  logic [16:0]        light_gain_i = '0;
  logic [13:0]        texel_addr_i = '0;
  logic [23:0]        texel_rgb_i = '0;
  logic               res_strobe_o, pixel_valid_o, done_res_o;
  logic signed [10:0] pix_x_o, pix_y_o;
  logic [7:0]         red_o, green_o, blue_o;

  raster_scoreboard sb = new();
  int idle_pct;
  int sent;

  textured_triangle_rasterizer #(.TEX_WORDS(TEX_WORDS)) u_dut (.*);

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    pixel_t got;
    if (rst_ni && res_strobe_o) begin
      got.valid = pixel_valid_o;
      got.x = pix_x_o;
      got.y = pix_y_o;
      got.r = red_o;
      got.g = green_o;
      got.b = blue_o;
      got.done = done_res_o;
      sb.check(got);
    end
  end

  task automatic send(logic [1:0] kind, logic [1:0] slot, logic signed [10:0] x,
                      logic signed [10:0] y, logic signed [10:0] u, logic signed [10:0] v,
                      logic [16:0] gain, logic [13:0] addr, logic [23:0] rgb);
    start <= 1'b1;
    kind_i <= kind;
    vertex_slot_i <= slot;
    vert_x_i <= x;
    vert_y_i <= y;
    vert_u_i <= u;
    vert_v_i <= v;
    light_gain_i <= gain;
    texel_addr_i <= addr;
    texel_rgb_i <= rgb;
    do @(posedge clk_i); while (busy);
    sb.note(kind, slot, x, y, u, v, gain, addr, rgb);
    if (!(kind == KIND_VERTEX && slot == 2'd3)) sent++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic put_texel(logic [13:0] addr, logic [23:0] rgb);
    send(KIND_TEXEL, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, addr, rgb);
  endtask

  task automatic put_vertex(logic [1:0] slot, logic signed [10:0] x, logic signed [10:0] y,
                            logic signed [10:0] u, logic signed [10:0] v);
    send(KIND_VERTEX, slot, x, y, u, v, $urandom, $urandom, $urandom);
  endtask

  task automatic begin_triangle(logic [16:0] gain);
    send(KIND_START, $urandom, $urandom, $urandom, $urandom, $urandom, gain, $urandom,
         $urandom);
  endtask

  // make sure the texel the step reads has been written first
  task automatic pixel_step();
    longint a;
    a = sb.fetch_addr();
    if (a >= 0 && !sb.written[a]) put_texel(a[13:0], $urandom);
    send(KIND_STEP, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0 || busy) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [7:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_WIDTH) sb.width = val;
    else sb.height = val;
  endtask

  function automatic logic [16:0] pick_gain();
    case ($urandom_range(4))
      0: return 17'd0;
      1: return 17'h1ffff;
      2: return 17'd65536;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_triangle();
    logic signed [10:0] x[3], y[3], u[3], v[3];
    int base_x, base_y, order, n;
    bit wide;
    wide = ($urandom_range(99) < 12);
    base_x = $urandom_range(2000) - 1000;
    base_y = $urandom_range(2000) - 1000;
    for (int i = 0; i < 3; i++) begin
      if (wide) begin
        x[i] = $urandom; y[i] = $urandom;
      end else begin
        x[i] = base_x + $urandom_range(12);
        y[i] = base_y + $urandom_range(10);
      end
      if ($urandom_range(99) < 10) begin
        u[i] = $urandom; v[i] = $urandom;
      end else begin
        u[i] = $urandom_range(sb.width + 3) - 2;
        v[i] = $urandom_range(sb.height + 3) - 2;
      end
    end
    order = $urandom_range(2);
    for (int i = 0; i < 3; i++) begin
      n = (i + order) % 3;
      put_vertex(n, x[n], y[n], u[n], v[n]);
      if ($urandom_range(99) < 5) put_vertex(2'd3, $urandom, $urandom, $urandom, $urandom);
    end
    if ($urandom_range(99) < 10) put_texel($urandom, $urandom);
    begin_triangle(pick_gain());
    n = $urandom_range(1, 60);
    for (int i = 0; i < n; i++) begin
      pixel_step();
      if (sb.phase == PH_IDLE) break;
    end
    if ($urandom_range(99) < 15) pixel_step();
  endtask

  initial begin
    int target;
    int ws[6] = '{128, 1, 7, 128, 1, 0};
    int hs[6] = '{128, 1, 9, 1, 128, 0};
    int pcts[6] = '{0, 76, 0, 13, 76, 0};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: idle step, texture extremes, vertex extremes, flat,
    // single-pixel spans, restart
    idle_pct = 0;
    pixel_step();
    put_texel(14'd0, 24'hffffff);
    put_texel(14'h3fff, 24'h000000);
    put_vertex(2'd0, -11'sd1024, -11'sd1024, -11'sd1024, -11'sd1024);
    put_vertex(2'd1, 11'sd1023, 11'sd1023, 11'sd1023, 11'sd1023);
    put_vertex(2'd3, 11'sd5, 11'sd5, 11'sd5, 11'sd5);
    put_vertex(2'd2, 11'sd0, 11'sd0, 11'sd0, 11'sd0);
    begin_triangle(17'h1ffff);
    repeat (3) pixel_step();
    put_vertex(2'd0, 11'sd0, 11'sd5, 11'sd0, 11'sd0);
    put_vertex(2'd1, 11'sd3, 11'sd5, 11'sd1, 11'sd1);
    put_vertex(2'd2, 11'sd6, 11'sd5, 11'sd2, 11'sd2);
    begin_triangle(17'd65536);
    pixel_step();
    put_vertex(2'd0, 11'sd10, 11'sd20, 11'sd3, 11'sd4);
    put_vertex(2'd1, 11'sd10, 11'sd21, 11'sd3, 11'sd4);
    put_vertex(2'd2, 11'sd10, 11'sd22, 11'sd127, 11'sd127);
    begin_triangle(17'd65536);
    repeat (4) pixel_step();
    put_vertex(2'd2, 11'sd30, 11'sd40, 11'sd20, 11'sd20);
    begin_triangle(17'd40000);
    repeat (2) pixel_step();
    begin_triangle(17'd0);
    repeat (2) pixel_step();

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_cfg(CFG_WIDTH, ws[ph] != 0 ? ws[ph] : $urandom_range(1, 128));
      write_cfg(CFG_HEIGHT, hs[ph] != 0 ? hs[ph] : $urandom_range(1, 128));
      idle_pct = pcts[ph];
      target = sent + 160;
      while (sent < target) random_triangle();
    end

    drain();
    $display("Sent %0d transactions over 6 texture sizes; checked %0d step results, %0d drawn.",
             sent, sb.checked, sb.drawn);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
